/* rtl/pce_pkg.sv */
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants for the polynomial coefficient list and
// Horner evaluator.
// ----------------------------------------------------------------------------
package pce_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int OUT_CNT_W    = 8;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 40;
    localparam int CAPACITY_DEF = 128;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [DATA_W-1:0]     value;
    } cell_ctrl_t;

    typedef struct packed {
        logic clr;
        logic step;
    } mac_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PUSH
    } state_t;

endpackage

/* rtl/pce_cell.sv */
// ----------------------------------------------------------------------------
// pce_cell
// One coefficient slot of the list. Shifts up from its lower neighbor on
// insert and rotates toward the head during evaluation.
// ----------------------------------------------------------------------------
module pce_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                       aclk,
    input  pce_pkg::cell_ctrl_t        ctrl_i,
    input  logic [CNT_W-1:0]           count_i,
    input  logic [CNT_W-1:0]           pos_i,
    input  logic [pce_pkg::DATA_W-1:0] left_i,
    input  logic [pce_pkg::DATA_W-1:0] right_i,
    input  logic [pce_pkg::DATA_W-1:0] head_i,
    output logic [pce_pkg::DATA_W-1:0] value_o
);
    import pce_pkg::*;

    localparam int              CW1    = CNT_W + 1;
    localparam logic [CNT_W:0]  IDX_X  = CW1'(IDX);
    localparam logic [CNT_W:0]  IDX1_X = CW1'(IDX + 1);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [CNT_W:0]    count_x;
    logic [CNT_W:0]    pos_x;

    assign count_x = {1'b0, count_i};
    assign pos_x   = {1'b0, pos_i};

    always_comb begin
        value_next = value_reg;
        case (ctrl_i.op)
            CELL_INSERT: begin
                if (pos_x == IDX_X) begin
                    value_next = ctrl_i.value;
                end else if (IDX_X > pos_x && IDX_X <= count_x) begin
                    value_next = left_i;
                end
            end
            CELL_ROTATE: begin
                if (IDX1_X == count_x) begin
                    value_next = head_i;
                end else if (IDX1_X < count_x) begin
                    value_next = right_i;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_o = value_reg;

endmodule

/* rtl/pce_mac.sv */
// ----------------------------------------------------------------------------
// pce_mac
// Horner accumulator: acc = acc * point + coefficient, wrapped to 32 bits.
// ----------------------------------------------------------------------------
module pce_mac (
    input  logic                       aclk,
    input  pce_pkg::mac_ctrl_t         ctrl_i,
    input  logic [pce_pkg::DATA_W-1:0] point_i,
    input  logic [pce_pkg::DATA_W-1:0] coeff_i,
    output logic [pce_pkg::DATA_W-1:0] acc_next_o
);
    import pce_pkg::*;

    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] prod;

    assign prod     = acc_reg * point_i;
    assign acc_next = prod + coeff_i;

    always_ff @(posedge aclk) begin
        if (ctrl_i.clr) begin
            acc_reg <= '0;
        end else if (ctrl_i.step) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_next_o = acc_next;

endmodule

/* rtl/poly_coeff_insert_and_eval.sv */
// ----------------------------------------------------------------------------
// poly_coeff_insert_and_eval
// Ordered list of signed coefficients, highest degree first, held in a row
// of cells. Inserts shift the row as they are accepted; evaluation
// rotates the row through a Horner accumulator, one coefficient per cycle.
//
//   channel  direction  handshake              payload
//   s_       in         s_tvalid / s_tready    tuser op, tdata coeff+position
//   m_       out        m_tvalid / m_tready    tuser status, tdata value+count
//   cfg_     in         cfg_valid / cfg_ready  cfg_data eval point
//
// Insert: the result passes through the result register to the output
// register. Evaluate: the rotation steps the single accumulator once per
// held coefficient, then the result goes the same way; an empty list skips
// the rotation. No new transaction is taken until the result has moved on.
// Reset clears the count, the control state and the eval point; cell
// contents are left as they are.
// The output register holds a result while m_tready is low; the next
// transaction is accepted meanwhile and its result waits until the register
// frees up.
// ----------------------------------------------------------------------------
module poly_coeff_insert_and_eval #(
    parameter int CAPACITY = pce_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tdata: [31:0] coefficient_value, [38:32] insert_position, [39] zero
    input  logic [pce_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: [0] op
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: [31:0] poly_value, [39:32] coeff_count
    output logic [pce_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: [0] status
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pce_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);
    import pce_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [DATA_W-1:0]     point_reg;
    logic [DATA_W-1:0]     res_val_reg;
    logic [DATA_W-1:0]     res_val_next;
    logic                  res_st_reg;
    logic                  res_st_next;
    logic [OUT_CNT_W-1:0]  res_cnt_reg;
    logic [OUT_CNT_W-1:0]  res_cnt_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [DATA_W-1:0]     m_val_reg;
    logic                  m_st_reg;
    logic [OUT_CNT_W-1:0]  m_cnt_reg;
    logic                  out_load;

    logic                  s_accept;
    logic [DATA_W-1:0]     in_coeff;
    logic [POS_W-1:0]      in_pos;
    logic [CNT_W+POS_W-1:0] pos_ext;
    logic [CNT_W+POS_W-1:0] cnt_ext;
    logic [CNT_W+POS_W-1:0] pos_clamp_ext;
    logic [CNT_W-1:0]      pos_clamp;
    logic [CNT_W-1:0]      count_inc;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_now_w;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_inc_w;
    logic                  list_full;

    cell_ctrl_t            cell_ctrl;
    mac_ctrl_t             mac_ctrl;
    logic [DATA_W-1:0]     mac_acc_next;
    logic [DATA_W-1:0]     cell_val [CAPACITY];

    assign in_coeff      = s_tdata[DATA_W-1:0];
    assign in_pos        = s_tdata[DATA_W+POS_W-1:DATA_W];
    assign s_tready      = (state_reg == ST_IDLE);
    assign s_accept      = s_tvalid & s_tready;
    assign cfg_ready     = 1'b1;

    assign pos_ext       = {{CNT_W{1'b0}}, in_pos};
    assign cnt_ext       = {{POS_W{1'b0}}, count_reg};
    assign pos_clamp_ext = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
    assign pos_clamp     = pos_clamp_ext[CNT_W-1:0];
    assign count_inc     = count_reg + 1'b1;
    assign cnt_now_w     = {{OUT_CNT_W{1'b0}}, count_reg};
    assign cnt_inc_w     = {{OUT_CNT_W{1'b0}}, count_inc};
    assign list_full     = (count_reg == CNT_W'(CAPACITY));

    // cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;
        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_left
            assign left_val = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_right
            assign right_val = cell_val[i+1];
        end
        pce_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .ctrl_i  (cell_ctrl),
            .count_i (count_reg),
            .pos_i   (pos_clamp),
            .left_i  (left_val),
            .right_i (right_val),
            .head_i  (cell_val[0]),
            .value_o (cell_val[i])
        );
    end

    pce_mac u_mac (
        .aclk       (aclk),
        .ctrl_i     (mac_ctrl),
        .point_i    (point_reg),
        .coeff_i    (cell_val[0]),
        .acc_next_o (mac_acc_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            point_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                point_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        res_cnt_reg <= res_cnt_next;
        if (out_load) begin
            m_val_reg <= res_val_reg;
            m_st_reg  <= res_st_reg;
            m_cnt_reg <= res_cnt_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_val_next    = res_val_reg;
        res_st_next     = res_st_reg;
        res_cnt_next    = res_cnt_reg;
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.value = in_coeff;
        mac_ctrl.clr    = 1'b0;
        mac_ctrl.step   = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_val_next = '0;
                    res_st_next  = STATUS_DONE;
                    res_cnt_next = cnt_now_w[OUT_CNT_W-1:0];
                    idx_next     = '0;
                    state_next   = ST_PUSH;
                    if (s_tuser == OP_INSERT) begin
                        if (list_full) begin
                            res_st_next = STATUS_DROPPED;
                        end else begin
                            cell_ctrl.op = CELL_INSERT;
                            count_next   = count_inc;
                            res_cnt_next = cnt_inc_w[OUT_CNT_W-1:0];
                        end
                    end else if (count_reg != '0) begin
                        mac_ctrl.clr = 1'b1;
                        state_next   = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                cell_ctrl.op  = CELL_ROTATE;
                mac_ctrl.step = 1'b1;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == count_reg - 1'b1) begin
                    res_val_next = mac_acc_next;
                    state_next   = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_tvalid_next = (m_tvalid_reg & ~m_tready) | out_load;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_st_reg;
    assign m_tdata  = {m_cnt_reg, m_val_reg};

`ifndef ASSERT_OFF
    a_eval_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (count_reg != '0))
        else $error("evaluation running on an empty list");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (idx_reg < count_reg))
        else $error("evaluation index past the held count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_INSERT && list_full) |=> $stable(count_reg))
        else $error("insert into a full list changed the count");
`endif

endmodule

/* test/pce_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_checker
// Watches the input, result and eval point channels of the polynomial list.
// Keeps its own coefficient row and count, works out the result of every
// accepted input transaction and compares each result transaction, field by
// field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pce_checker #(
    parameter int CAPACITY = pce_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pce_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [pce_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pce_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    output int                            mismatch_count,
    output int                            results_due,
    output int                            results_seen
);
    import pce_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]    value;
        logic                 status;
        logic [OUT_CNT_W-1:0] count;
    } poly_result_t;

    logic [DATA_W-1:0] coeff_row [CAPACITY];
    int                held;
    logic [DATA_W-1:0] eval_point;
    poly_result_t      due_results[$];

    initial begin
        mismatch_count = 0;
        results_due    = 0;
        results_seen   = 0;
        held           = 0;
        eval_point     = '0;
    end

    function automatic poly_result_t step_poly_list(input logic op,
                                                    input logic [DATA_W-1:0] coeff,
                                                    input logic [POS_W-1:0] pos);
        poly_result_t      r;
        int                slot;
        logic [DATA_W-1:0] acc;
        r.value  = '0;
        r.status = STATUS_DONE;
        if (op == OP_INSERT) begin
            if (held >= CAPACITY) begin
                r.status = STATUS_DROPPED;
            end else begin
                // clamp a position past the end so the coefficient is appended
                slot = (pos > held) ? held : int'(pos);
                for (int i = held; i > slot; i--) coeff_row[i] = coeff_row[i-1];
                coeff_row[slot] = coeff;
                held++;
            end
        end else begin
            acc = '0;
            for (int j = 0; j < held; j++) acc = acc * eval_point + coeff_row[j];
            r.value = acc;
        end
        r.count = held[OUT_CNT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        poly_result_t seen;
        poly_result_t want;
        if (!aresetn) begin
            held       = 0;
            eval_point = '0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) eval_point = cfg_data;
            if (s_tvalid && s_tready)
                due_results.push_back(step_poly_list(s_tuser, s_tdata[DATA_W-1:0],
                                                     s_tdata[DATA_W+POS_W-1:DATA_W]));
            if (m_tvalid && m_tready) begin
                seen.value  = m_tdata[DATA_W-1:0];
                seen.count  = m_tdata[DATA_W+OUT_CNT_W-1:DATA_W];
                seen.status = m_tuser;
                results_seen++;
                if (due_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result: value %h status %0d count %0d",
                                 seen.value, seen.status, seen.count);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (seen.value !== want.value || seen.status !== want.status ||
                        seen.count !== want.count) begin
                        if (mismatch_count < 10)
                            $display({"mismatch: value exp %h got %h, status exp %0d ",
                                      "got %0d, count exp %0d got %0d"},
                                     want.value, seen.value, want.status, seen.status,
                                     want.count, seen.count);
                        mismatch_count++;
                    end
                end
            end
        end
        results_due <= due_results.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the polynomial list with a directed opening (empty list, clamped
// positions, extreme coefficients and eval points) and then random phases of
// inserts and evaluations that fill the list, overflow it and evaluate it as
// it grows, with random gaps and back-pressure. Results are checked by
// pce_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import pce_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int RANDOM_OPS  = 900;
    localparam int RUN_LIMIT   = 1000000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = OP_INSERT;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    int          mismatch_count;
    int          results_due;
    int          results_seen;
    int          cycle_count = 0;
    logic        steady_flow = 1'b1;
    int          ready_hold  = 0;
    int unsigned ready_roll;
    int          n_insert    = 0;
    int          n_eval      = 0;
    int          n_points    = 0;
    int          n_held      = 0;
    int          n_dropped   = 0;

    poly_coeff_insert_and_eval #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_data (cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready)
    );

    pce_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .mismatch_count(mismatch_count),
        .results_due   (results_due),
        .results_seen  (results_seen)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (steady_flow) begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 7);
            end else if (ready_roll < 95) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(20, 60);
            end
        end
    end

    task automatic send_item(input logic op, input logic [DATA_W-1:0] coeff,
                             input logic [POS_W-1:0] pos);
        int          gap;
        int unsigned roll;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (!steady_flow) begin
            if (roll >= 90) gap = $urandom_range(10, 40);
            else if (roll >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {1'b0, pos, coeff};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_EVAL) begin
            n_eval++;
        end else begin
            n_insert++;
            if (n_held < CAPACITY) n_held++;
            else n_dropped++;
        end
    endtask

    task automatic set_point(input logic [DATA_W-1:0] point);
        // hold off until every outstanding result has been taken
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        cfg_data  <= point;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_points++;
    endtask

    initial begin
        int                phase_len;
        int unsigned       roll;
        logic              op;
        logic [DATA_W-1:0] coeff;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] point;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening
        send_item(OP_EVAL,   32'h0000_0000, 7'd0);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 7'd127);
        send_item(OP_INSERT, 32'h8000_0000, 7'd0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 7'd1);
        send_item(OP_INSERT, 32'h0000_0000, 7'd3);
        send_item(OP_INSERT, 32'h0000_0005, 7'd100);
        send_item(OP_EVAL,   32'hFFFF_FFFF, 7'd127);
        set_point(32'h0000_0001);
        send_item(OP_EVAL,   32'h0000_0000, 7'd0);
        set_point(32'hFFFF_FFFF);
        send_item(OP_EVAL,   32'h0000_0000, 7'd0);
        set_point(32'h7FFF_FFFF);
        send_item(OP_EVAL,   32'h0000_0000, 7'd0);
        send_item(OP_INSERT, 32'h5555_5555, 7'd2);
        send_item(OP_INSERT, 32'hAAAA_AAAA, 7'd7);
        send_item(OP_EVAL,   32'h0000_0000, 7'd0);
        set_point(32'h8000_0000);
        send_item(OP_EVAL,   32'h0000_0000, 7'd0);
        set_point(32'h0000_0002);
        send_item(OP_EVAL,   32'h0000_0000, 7'd0);

        // random phases
        while (n_insert + n_eval < RANDOM_OPS + 20) begin
            roll = $urandom_range(0, 9);
            case (roll)
                0: point = 32'h0000_0000;
                1: point = 32'h0000_0001;
                2: point = 32'hFFFF_FFFF;
                3: point = 32'h7FFF_FFFF;
                4: point = 32'h8000_0000;
                5: point = $urandom_range(0, 6) - 3;
                default: point = $urandom();
            endcase
            set_point(point);
            steady_flow <= ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 80);
            repeat (phase_len) begin
                op = ($urandom_range(0, 99) < 30) ? OP_INSERT : OP_EVAL;
                roll = $urandom_range(0, 7);
                case (roll)
                    0: coeff = 32'h8000_0000;
                    1: coeff = 32'h7FFF_FFFF;
                    2: coeff = $urandom_range(0, 8) - 4;
                    default: coeff = $urandom();
                endcase
                if ($urandom_range(0, 1) == 0)
                    pos = $urandom_range(0, 127);
                else
                    pos = $urandom_range(0, (n_held < 127) ? n_held : 127);
                send_item(op, coeff, pos);
            end
        end

        // drain
        s_tvalid    <= 1'b0;
        steady_flow <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (CAPACITY + 8) @(posedge aclk);

        $display("Covered %0d inserts (%0d on a full list) and %0d evaluations at %0d points",
                 n_insert, n_dropped, n_eval, n_points);
        $display("List grew to %0d coefficients; %0d results compared, %0d mismatches",
                 n_held, results_seen, mismatch_count);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* poly_coeff_insert_and_eval.f */
rtl/pce_pkg.sv
rtl/pce_cell.sv
rtl/pce_mac.sv
rtl/poly_coeff_insert_and_eval.sv
test/pce_checker.sv
test/tb_top.sv
